>>> rtl/rppt_pkg.sv
// ----------------------------------------------------------------------------
// rppt_pkg: shared definitions for the page presence table
// Operation codes, register indexes, default sizes and the item-kind struct
// passed from the classifier through the queue to the counter engine.
// ----------------------------------------------------------------------------
package rppt_pkg;

  // Default geometry
  localparam int PAGE_OFFSET_BITS_DEF     = 12;
  localparam int ENTRY_INDEX_BITS_DEF     = 8;
  localparam int DIRECTORY_INDEX_BITS_DEF = 8;
  localparam int ADDRESS_WIDTH_DEF        = 40;
  localparam int COUNT_WIDTH_DEF          = 16;

  // Operation codes (code 3 behaves as a query)
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

  // Result width of out_tdata
  localparam int OUT_DATA_W = 8;

  // Classified item kind
  typedef struct packed {
    logic is_map;
    logic is_unmap;
    logic oor;
  } item_kind_t;

  // Status from the counter engine to the front end
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

>>> rtl/rppt_front.sv
// ----------------------------------------------------------------------------
// rppt_front: window check and classification
// Holds the window registers, checks each incoming address against the
// window, splits the offset into a slot index and pushes the item to the queue.
// ----------------------------------------------------------------------------
module rppt_front
  import rppt_pkg::*;
#(
  parameter int PAGE_OFFSET_BITS     = PAGE_OFFSET_BITS_DEF,
  parameter int ENTRY_INDEX_BITS     = ENTRY_INDEX_BITS_DEF,
  parameter int DIRECTORY_INDEX_BITS = DIRECTORY_INDEX_BITS_DEF,
  parameter int ADDRESS_WIDTH        = ADDRESS_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // configuration
  input  logic                                          cfg_wen,
  input  logic [CFG_IDX_W-1:0]                          cfg_index,
  input  logic [ADDRESS_WIDTH-1:0]                      cfg_wdata,
  // input item
  input  logic                                          item_valid,
  output logic                                          item_ready,
  input  logic [OP_W-1:0]                               item_op,
  input  logic [ADDRESS_WIDTH-1:0]                      item_addr,
  // queue side
  output logic                                          q_push,
  input  logic                                          q_ready,
  output item_kind_t                                    q_kind,
  output logic [DIRECTORY_INDEX_BITS+ENTRY_INDEX_BITS-1:0] q_slot,
  input  back_stat_t                                    back_stat
);

  localparam int SLOT_W = DIRECTORY_INDEX_BITS + ENTRY_INDEX_BITS;
  localparam int TOP_B  = PAGE_OFFSET_BITS + SLOT_W;
  localparam int OFF_W  = (ADDRESS_WIDTH > TOP_B) ? ADDRESS_WIDTH : TOP_B;

  logic [ADDRESS_WIDTH-1:0] win_base_r;
  logic [ADDRESS_WIDTH-1:0] win_size_r;
  logic [ADDRESS_WIDTH:0]   diff;
  logic [OFF_W-1:0]         off_ext;
  logic                     below, beyond;

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_base_r <= '0;
      win_size_r <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_WINDOW_BASE: win_base_r <= cfg_wdata;
        REG_WINDOW_SIZE: win_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Window check: borrow of the subtraction marks an address below the base
  always_comb begin
    diff    = {1'b0, item_addr} - {1'b0, win_base_r};
    below   = diff[ADDRESS_WIDTH];
    beyond  = diff[ADDRESS_WIDTH-1:0] >= win_size_r;
    off_ext = OFF_W'(diff[ADDRESS_WIDTH-1:0]);
  end

  // Classification; unused op code falls through to a query
  always_comb begin
    q_kind.oor      = below | beyond;
    q_kind.is_map   = (item_op == OP_MAP);
    q_kind.is_unmap = (item_op == OP_UNMAP);
    q_slot          = off_ext[TOP_B-1:PAGE_OFFSET_BITS];
  end

  assign item_ready = q_ready & ~back_stat.clearing;
  assign q_push     = item_valid & item_ready;

endmodule

>>> rtl/rppt_queue.sv
// ----------------------------------------------------------------------------
// rppt_queue: two-entry item queue
// Decouples the classifier from the counter engine so either may stall.
// ----------------------------------------------------------------------------
module rppt_queue
  import rppt_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slots_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> pop_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> push_ready)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue occupancy lost a push");

endmodule

>>> rtl/rppt_back.sv
// ----------------------------------------------------------------------------
// rppt_back: counter engine
// Owns the directory valid bits and the counter memory. Clears both memories
// after reset, then runs one read-modify-write per item and registers the result.
// ----------------------------------------------------------------------------
module rppt_back
  import rppt_pkg::*;
#(
  parameter int ENTRY_INDEX_BITS     = ENTRY_INDEX_BITS_DEF,
  parameter int DIRECTORY_INDEX_BITS = DIRECTORY_INDEX_BITS_DEF,
  parameter int COUNT_WIDTH          = COUNT_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  // queue side
  input  logic                                             q_valid,
  output logic                                             q_pop,
  input  item_kind_t                                       q_kind,
  input  logic [DIRECTORY_INDEX_BITS+ENTRY_INDEX_BITS-1:0] q_slot,
  output back_stat_t                                       back_stat,
  // result
  output logic                                             res_valid,
  input  logic                                             res_ready,
  output logic                                             res_present,
  output logic                                             res_oor,
  output logic                                             res_sat
);

  localparam int SLOT_W  = DIRECTORY_INDEX_BITS + ENTRY_INDEX_BITS;
  localparam int DIRS    = 1 << DIRECTORY_INDEX_BITS;
  localparam int SLOTS   = 1 << SLOT_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [1:0]              state_r, state_nxt;
  logic [SLOT_W-1:0]       clr_idx_r;
  logic                    dir_mem [DIRS];
  logic                    dv_r;
  logic [COUNT_WIDTH-1:0]  mem [SLOTS];
  logic [COUNT_WIDTH-1:0]  rd_data_r;
  item_kind_t              kind_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    out_valid_r;
  logic                    present_r, oor_r, sat_r;

  logic                    exec;
  logic                    dv;
  logic [DIRECTORY_INDEX_BITS-1:0] dir_idx;
  logic                    nz;
  logic                    wr_en;
  logic [SLOT_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0]  wr_data;
  logic                    ans, sat;
  logic [COUNT_WIDTH-1:0]  dec;

  assign exec      = (state_r == ST_EXEC);
  assign q_pop     = (state_r == ST_IDLE) && q_valid && (!out_valid_r || res_ready);
  assign back_stat.clearing = (state_r == ST_CLEAR);

  // Item evaluation on the counter and valid bit read back from memory
  always_comb begin
    dir_idx = slot_r[SLOT_W-1:ENTRY_INDEX_BITS];
    dv      = dv_r;
    nz      = (rd_data_r != '0);
    dec     = nz ? rd_data_r - COUNT_WIDTH'(1) : rd_data_r;
    ans     = 1'b0;
    sat     = 1'b0;
    wr_en   = 1'b0;
    wr_data = rd_data_r;
    if (!kind_r.oor) begin
      if (kind_r.is_map) begin
        ans = nz;
        if (rd_data_r == CNT_MAX) begin
          sat = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data_r + COUNT_WIDTH'(1);
        end
      end else if (kind_r.is_unmap) begin
        if (dv) begin
          wr_en   = 1'b1;
          wr_data = dec;
          ans     = (dec != '0);
        end
      end else begin
        ans = dv & nz;
      end
    end
  end

  // Memory write port: clearing sweep or item write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_addr = clr_idx_r;
    end else begin
      wr_addr = slot_r;
    end
  end

  // Counter and directory memories; the sweep also covers every directory
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[wr_addr] <= '0;
      dir_mem[clr_idx_r[DIRECTORY_INDEX_BITS-1:0]] <= 1'b0;
    end else if (exec) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (kind_r.is_map && !kind_r.oor) dir_mem[dir_idx] <= 1'b1;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_slot];
      dv_r      <= dir_mem[q_slot[SLOT_W-1:ENTRY_INDEX_BITS]];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_idx_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_pop) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + SLOT_W'(1);
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_kind;
      slot_r <= q_slot;
    end
    if (exec) begin
      present_r <= ans;
      oor_r     <= kind_r.oor;
      sat_r     <= sat;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_present = present_r;
  assign res_oor     = oor_r;
  assign res_sat     = sat_r;

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> (!out_valid_r || res_ready))
    else $error("item taken while result slot still occupied");
  assert property (@(posedge clk) disable iff (!rst_n) exec |=> out_valid_r)
    else $error("executed item produced no result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!q_pop && !out_valid_r))
    else $error("activity during counter clearing");
  assert property (@(posedge clk) disable iff (!rst_n) (exec && sat_r == sat && sat) |-> kind_r.is_map)
    else $error("saturation flagged on a non-map item");

endmodule

>>> rtl/refcounted_page_presence_table_unit.sv
// Path: an accepted item is written into the queue, then popped into the engine's item registers,
// and its result is registered onto out_tdata; the engine pops no new item until that one is done.
// The result register and the two-entry queue let input transfers continue while a result waits.
// Reset: synchronous, active low; clears the window registers at once.
// After reset the counter memory and directory bits are cleared one entry a cycle,
// over all 2^(DIRECTORY+ENTRY index bits) entries (65536 by default); in_tready stays low until then.
// ----------------------------------------------------------------------------
// refcounted_page_presence_table_unit: reference-counted page presence table
// Map, unmap and query of per-page reference counts in a two-level table
// inside a configurable address window; one result per input transfer.
// ----------------------------------------------------------------------------
module refcounted_page_presence_table_unit
  import rppt_pkg::*;
#(
  parameter int PAGE_OFFSET_BITS     = PAGE_OFFSET_BITS_DEF,
  parameter int ENTRY_INDEX_BITS     = ENTRY_INDEX_BITS_DEF,
  parameter int DIRECTORY_INDEX_BITS = DIRECTORY_INDEX_BITS_DEF,
  parameter int ADDRESS_WIDTH        = ADDRESS_WIDTH_DEF,
  parameter int COUNT_WIDTH          = COUNT_WIDTH_DEF,
  localparam int IN_DATA_W           = ((ADDRESS_WIDTH + OP_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wen,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [ADDRESS_WIDTH-1:0] cfg_wdata,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_W-1:0]     in_tdata,   // operation, address, zero pad
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_W-1:0]    out_tdata   // present_answer, out_of_range,
                                               // count_saturated, zero pad
);

  localparam int SLOT_W = DIRECTORY_INDEX_BITS + ENTRY_INDEX_BITS;
  localparam int ITEM_W = $bits(item_kind_t) + SLOT_W;

  item_kind_t        f_kind, b_kind;
  logic [SLOT_W-1:0] f_slot, b_slot;
  logic              q_push, q_ready, q_pop, q_valid;
  logic [ITEM_W-1:0] q_out;
  back_stat_t        back_stat;
  logic              res_present, res_oor, res_sat;

  rppt_front #(
    .PAGE_OFFSET_BITS     (PAGE_OFFSET_BITS),
    .ENTRY_INDEX_BITS     (ENTRY_INDEX_BITS),
    .DIRECTORY_INDEX_BITS (DIRECTORY_INDEX_BITS),
    .ADDRESS_WIDTH        (ADDRESS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_op    (in_tdata[OP_W-1:0]),
    .item_addr  (in_tdata[OP_W+ADDRESS_WIDTH-1:OP_W]),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_kind     (f_kind),
    .q_slot     (f_slot),
    .back_stat  (back_stat)
  );

  rppt_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  ({f_kind, f_slot}),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  assign b_kind = q_out[ITEM_W-1:SLOT_W];
  assign b_slot = q_out[SLOT_W-1:0];

  rppt_back #(
    .ENTRY_INDEX_BITS     (ENTRY_INDEX_BITS),
    .DIRECTORY_INDEX_BITS (DIRECTORY_INDEX_BITS),
    .COUNT_WIDTH          (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_kind      (b_kind),
    .q_slot      (b_slot),
    .back_stat   (back_stat),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_present (res_present),
    .res_oor     (res_oor),
    .res_sat     (res_sat)
  );

  assign out_tdata = {{(OUT_DATA_W-3){1'b0}}, res_sat, res_oor, res_present};

endmodule

>>> tb/tb_refcounted_page_presence_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_presence_table_unit: self-checking bench for the table
// Drives map, unmap and query transfers under several window settings and
// checks every result against a local model of the directory bits and counts.
// Covers directed corner cases, count build-up and release, and random traffic.
// ----------------------------------------------------------------------------
module tb_refcounted_page_presence_table_unit;
  import rppt_pkg::*;

  localparam int PG_BITS  = PAGE_OFFSET_BITS_DEF;
  localparam int ENT_BITS = ENTRY_INDEX_BITS_DEF;
  localparam int DIR_BITS = DIRECTORY_INDEX_BITS_DEF;
  localparam int ADDR_W   = ADDRESS_WIDTH_DEF;
  localparam int CNT_W    = COUNT_WIDTH_DEF;
  localparam int IN_W     = ((ADDR_W + OP_W + 7) / 8) * 8;
  localparam int SLOT_W   = DIR_BITS + ENT_BITS;
  localparam int STALL_LIMIT = 200000;
  // code 3 is not a named operation; the block treats it as a query
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
  } page_request_t;

  // lowest bit first on out_tdata: present, out of range, saturated
  typedef struct packed {
    logic saturated;
    logic out_of_range;
    logic present;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;     // operation, address, zero pad
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;   // present_answer, out_of_range, count_saturated, pad

  // model state
  logic [ADDR_W-1:0] win_base = '0;
  logic [ADDR_W-1:0] win_size = '0;
  logic dir_valid [2**DIR_BITS];
  logic [CNT_W-1:0] page_count [2**SLOT_W];

  page_request_t queued_requests[$];
  page_result_t  expected_results[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int in_idle_left = 0;
  int out_stall_left = 0;
  bit no_idling = 1'b0;
  logic [ADDR_W-1:0] hot_pages [8];

  refcounted_page_presence_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 2**DIR_BITS; i++) dir_valid[i] = 1'b0;
    for (int i = 0; i < 2**SLOT_W; i++) page_count[i] = '0;
  end

  // Apply one access to the table model and return its result
  function automatic page_result_t predict_page_access(logic [OP_W-1:0] op,
                                                       logic [ADDR_W-1:0] addr);
    page_result_t res;
    logic [ADDR_W-1:0] off;
    logic [DIR_BITS-1:0] dir;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] cnt;
    res = '0;
    if (addr < win_base || (addr - win_base) >= win_size) begin
      res.out_of_range = 1'b1;
    end else begin
      off  = addr - win_base;
      dir  = off[PG_BITS+ENT_BITS +: DIR_BITS];
      slot = off[PG_BITS +: SLOT_W];
      cnt  = page_count[slot];
      case (op)
        OP_MAP: begin
          dir_valid[dir] = 1'b1;
          res.present = (cnt != 0);
          if (cnt == '1) res.saturated = 1'b1;
          else page_count[slot] = cnt + 1'b1;
        end
        OP_UNMAP: begin
          if (dir_valid[dir]) begin
            if (cnt != 0) cnt = cnt - 1'b1;
            page_count[slot] = cnt;
            res.present = (cnt != 0);
          end
        end
        default: begin
          if (dir_valid[dir]) res.present = (cnt != 0);
        end
      endcase
    end
    return res;
  endfunction

  // Request driver
  always @(posedge clk) begin
    page_request_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_idle_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (!no_idling && in_idle_left > 0) begin
        in_idle_left = in_idle_left - 1;
        in_tvalid <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 9) == 0) begin
        in_idle_left = $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else if (queued_requests.size() > 0) begin
        req = queued_requests.pop_front();
        in_tdata <= {{(IN_W-ADDR_W-OP_W){1'b0}}, req.addr, req.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(posedge clk) begin
    if (no_idling) begin
      out_tready <= 1'b1;
    end else if (out_stall_left > 0) begin
      out_stall_left = out_stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_left = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result check, prediction of accepted requests and watchdog
  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    bit in_fire;
    bit out_fire;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (out_fire) begin
      got = out_tdata[2:0];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %03b", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.present !== want.present) begin
          mismatch_count++;
          $display("%0t: present_answer expected %0b actual %0b",
                   $time, want.present, got.present);
        end
        if (got.out_of_range !== want.out_of_range) begin
          mismatch_count++;
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.out_of_range, got.out_of_range);
        end
        if (got.saturated !== want.saturated) begin
          mismatch_count++;
          $display("%0t: count_saturated expected %0b actual %0b",
                   $time, want.saturated, got.saturated);
        end
      end
    end
    if (in_fire)
      expected_results.push_back(predict_page_access(in_tdata[OP_W-1:0],
                                                     in_tdata[OP_W +: ADDR_W]));
    if (in_fire || out_fire) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("refcounted_page_presence_table_unit verification failed");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'({$urandom, $urandom});
    return a;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_WINDOW_BASE) win_base = value;
    else win_size = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    write_reg(REG_WINDOW_BASE, base);
    write_reg(REG_WINDOW_SIZE, size);
  endtask

  task automatic push_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    page_request_t req;
    req.op = op;
    req.addr = addr;
    queued_requests.push_back(req);
  endtask

  // Wait until every result is back, then let the pipeline drain
  task automatic wait_drained();
    @(negedge clk);
    while (queued_requests.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Random traffic, mostly on a few hot pages so that counts build up
  task automatic push_random(int n);
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] addr;
    logic [OP_W-1:0] op;
    int pick;
    span = (win_size > (1 << 28) || win_size == 0) ? (1 << 28) : win_size;
    for (int i = 0; i < 8; i++) hot_pages[i] = rand_addr() % span;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        addr = win_base + hot_pages[$urandom_range(0, 7)] + $urandom_range(0, 4095);
      else if (pick < 78 && win_size != 0)
        addr = win_base + rand_addr() % win_size;
      else if (pick < 95)
        addr = rand_addr();
      else if (pick < 97)
        addr = win_base - 1'b1;
      else if (pick < 99)
        addr = win_base + win_size;
      else
        addr = win_base + win_size - 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_MAP;
      else if (pick < 75) op = OP_UNMAP;
      else if (pick < 95) op = OP_QUERY;
      else op = OP_SPARE;
      push_req(op, addr);
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [ADDR_W-1:0] count_page;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty window after reset: everything out of range
    push_req(OP_MAP, '0);
    push_req(OP_QUERY, ADDR_TOP);
    wait_drained();

    // window over all but the top address: map, release and query paths
    set_window('0, ADDR_TOP);
    push_req(OP_MAP, '0);
    push_req(OP_MAP, '0);
    push_req(OP_QUERY, '0);
    push_req(OP_SPARE, '0);
    push_req(OP_UNMAP, '0);
    push_req(OP_UNMAP, '0);
    push_req(OP_UNMAP, '0);                 // count already zero, held
    push_req(OP_QUERY, '0);
    push_req(OP_UNMAP, 40'h55_5550_0000);   // directory never mapped
    push_req(OP_QUERY, 40'hAA_AAA0_0000);
    push_req(OP_MAP, ADDR_TOP - 1'b1);
    push_req(OP_QUERY, 40'hFF_FFFF_F000);
    push_req(OP_MAP, ADDR_TOP);             // one past the window end
    push_req(OP_MAP, 40'h10_0000_0000);     // offset above the index bits wraps
    push_req(OP_QUERY, '0);
    wait_drained();

    // window reaching the top of the address space
    set_window(40'hFF_FFFF_0000, ADDR_TOP);
    push_req(OP_MAP, 40'hFF_FFFE_FFFF);
    push_req(OP_MAP, 40'hFF_FFFF_0000);
    push_req(OP_UNMAP, ADDR_TOP);
    wait_drained();
    set_window(ADDR_TOP, 40'd1);
    push_req(OP_MAP, ADDR_TOP);
    push_req(OP_QUERY, ADDR_TOP);
    push_req(OP_MAP, '0);
    wait_drained();
    set_window(40'h12_3456_7000, '0);
    push_req(OP_MAP, 40'h12_3456_7000);
    wait_drained();

    // build up one page's count, then release it past zero
    set_window(40'h12_3456_7000, 40'h1000_0000);
    count_page = 40'h12_3456_7000 + 40'h0345_6000;
    for (int i = 0; i < 4; i++) push_req(OP_MAP, count_page);
    for (int i = 0; i < 5; i++) push_req(OP_UNMAP, count_page);
    push_req(OP_QUERY, count_page);
    wait_drained();

    // random traffic under several windows
    set_window(rand_addr(), (40'd1 << $urandom_range(13, 30)) + $urandom_range(0, 4095));
    push_random(350);
    wait_drained();
    set_window('0, ADDR_TOP);
    push_random(350);
    wait_drained();
    set_window(rand_addr(), rand_addr());
    push_random(350);
    wait_drained();
    no_idling = 1'b1;
    set_window(rand_addr() >> 1, 40'h1000_0000);
    push_random(350);
    wait_drained();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("refcounted_page_presence_table_unit verification clean");
    end else begin
      $display("refcounted_page_presence_table_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rppt_pkg.sv
rtl/rppt_front.sv
rtl/rppt_queue.sv
rtl/rppt_back.sv
rtl/refcounted_page_presence_table_unit.sv
tb/tb_refcounted_page_presence_table_unit.sv
